// File: rtl/sct_pkg.sv
package sct_pkg;

    // Field widths on the stream ports
    localparam int ANGLE_W = 24;
    localparam int FUNC_W  = 1;
    localparam int VALUE_W = 20;
    localparam int TDATA_S_W = 24;
    localparam int TDATA_M_W = 24;

    // Internal fixed point: Q.32 values, magnitude stays far below 2^11
    localparam int Q_FRAC = 32;
    localparam int ACC_W  = 44;   // Horner accumulator and A operand
    localparam int MB_W   = 40;   // B operand (x or x^2)
    localparam int MB_HALF = 20;  // B is consumed in two 20-bit digits
    localparam int PP_W   = ACC_W + MB_HALF + 1;
    localparam int SUM_W  = ACC_W + MB_W;
    localparam int RED_W  = 28;   // angle register, wide enough for 2*pi at up to 24 fraction bits
    localparam int K_W    = 4;    // term index as seen by the coefficient table

    localparam logic [FUNC_W-1:0] FUNC_SINE   = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_COSINE = 1'b1;

    // Command to the shared multiply-accumulate unit
    typedef struct packed {
        logic lo;    // multiply A by the low digit of B
        logic hi;    // multiply A by the high digit of B, seed the sum
        logic fold;  // add the shifted high partial product
    } t_mac_cmd;

    // 1/n! in Q.32, rounded half up; zero below the Q.32 resolution
    function automatic logic signed [ACC_W-1:0] inv_fact(input logic [K_W:0] n);
        logic signed [ACC_W-1:0] v;
        case (n)
            5'd0:    v = 44'sd4294967296;
            5'd1:    v = 44'sd4294967296;
            5'd2:    v = 44'sd2147483648;
            5'd3:    v = 44'sd715827883;
            5'd4:    v = 44'sd178956971;
            5'd5:    v = 44'sd35791394;
            5'd6:    v = 44'sd5965232;
            5'd7:    v = 44'sd852176;
            5'd8:    v = 44'sd106522;
            5'd9:    v = 44'sd11836;
            5'd10:   v = 44'sd1184;
            5'd11:   v = 44'sd108;
            5'd12:   v = 44'sd9;
            5'd13:   v = 44'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Series coefficient of term k: (-1)^k/(2k+1)! for sine, (-1)^k/(2k)! for cosine
    function automatic logic signed [ACC_W-1:0] coeff(input logic [K_W-1:0] k,
                                                      input logic          cosine);
        logic [K_W:0]            n;
        logic signed [ACC_W-1:0] c;
        n = cosine ? {k, 1'b0} : {k, 1'b1};
        c = inv_fact(n);
        return k[0] ? -c : c;
    endfunction

endpackage

// File: rtl/sine_cosine_taylor_series.sv
// Channel   Dir  Handshake          Payload
// --------  ---  -----------------  ----------------------------------------------
// request   in   s_tvalid/s_tready  s_tdata: angle Q8.16 signed; s_tuser: func
// result    out  m_tvalid/m_tready  m_tdata: value Q4.16 signed, saturated
//
// One request at a time. The angle is first brought into [-2*pi, 2*pi] by s steps
// of 2*pi, one per cycle; with the defaults s is at most 20. Then x^2 is formed,
// the Horner loop runs from the top term down, and sine ends with one more product
// by x. Every product goes through one 44x21 multiplier, as a lo, a hi and a fold
// step per Q.32 multiply.
// Reset (synchronous, active low) returns the sequencer to idle and drops any
// pending result. A stalled result sits in the output register and the sequencer
// holds in its final state until that register is free.
module sine_cosine_taylor_series #(
    parameter int MAX_TERM_INDEX  = 8,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sct_pkg::TDATA_S_W-1:0]   s_tdata,   // [23:0] angle
    input  logic [sct_pkg::FUNC_W-1:0]      s_tuser,   // [0] func (0 sine, 1 cosine)
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sct_pkg::TDATA_M_W-1:0]   m_tdata    // [19:0] value, [23:20] zero
);

    localparam int KW = $clog2(MAX_TERM_INDEX + 1);

    // 2*pi at the angle's scale, rounded half up from the Q.32 constant
    localparam logic [63:0] TWO_PI_Q32 = 64'h6487ED511;
    localparam logic signed [sct_pkg::RED_W-1:0] TWO_PI = sct_pkg::RED_W'(
        (TWO_PI_Q32 + (64'd1 << (31 - ANGLE_FRAC_BITS))) >> (32 - ANGLE_FRAC_BITS));

    localparam logic [KW-1:0] K_LAST = KW'(MAX_TERM_INDEX - 1);

    localparam logic signed [sct_pkg::ACC_W-1:0] SAT_MAX =
        sct_pkg::ACC_W'((64'sd1 <<< (sct_pkg::VALUE_W - 1)) - 64'sd1);
    localparam logic signed [sct_pkg::ACC_W-1:0] SAT_MIN =
        -sct_pkg::ACC_W'(64'sd1 <<< (sct_pkg::VALUE_W - 1));

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_REDUCE = 3'd1;
    localparam logic [2:0] ST_LO     = 3'd2;
    localparam logic [2:0] ST_HI     = 3'd3;
    localparam logic [2:0] ST_FOLD   = 3'd4;
    localparam logic [2:0] ST_X2     = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    // Which multiply the shared unit is running
    localparam logic [1:0] K_SQ     = 2'd0;   // x*x
    localparam logic [1:0] K_HORNER = 2'd1;   // acc*x^2 + c[k]
    localparam logic [1:0] K_FIN    = 2'd2;   // acc*x, sine only

    logic [2:0]                          r_state, n_state;
    logic [1:0]                          r_kind, n_kind;
    logic [KW-1:0]                       r_k, n_k;
    logic                                r_ovalid, n_ovalid;
    logic signed [sct_pkg::RED_W-1:0]    r_a, n_a;
    logic                                r_cos, n_cos;
    logic signed [sct_pkg::ACC_W-1:0]    r_x2, n_x2;
    logic [sct_pkg::VALUE_W-1:0]         r_odata, n_odata;

    logic                                s_accept;
    logic                                out_free;
    logic signed [sct_pkg::RED_W-1:0]    a_dn, a_up;
    logic                                a_high, a_low;
    logic signed [sct_pkg::ACC_W-1:0]    x_q32;
    logic signed [sct_pkg::ACC_W-1:0]    mac_a, mac_c, mac_q;
    logic signed [sct_pkg::MB_W-1:0]     mac_b;
    logic signed [sct_pkg::ACC_W-17:0]   q_shift;
    logic [sct_pkg::VALUE_W-1:0]         q_sat;
    sct_pkg::t_mac_cmd                   mac_cmd;

    assign s_tready = (r_state == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !r_ovalid || m_tready;

    assign m_tvalid = r_ovalid;
    assign m_tdata  = sct_pkg::TDATA_M_W'(r_odata);

    // One 2*pi step per cycle
    assign a_dn   = r_a - TWO_PI;
    assign a_up   = r_a + TWO_PI;
    assign a_high = r_a > TWO_PI;
    assign a_low  = r_a < -TWO_PI;

    // Reduced angle at Q.32
    assign x_q32 = sct_pkg::ACC_W'(r_a) <<< (sct_pkg::Q_FRAC - ANGLE_FRAC_BITS);

    // Operand select for the shared unit; mac_q still holds the previous
    // result through the lo and hi phases
    always_comb begin
        case (r_kind)
            K_SQ: begin
                mac_a = x_q32;
                mac_b = x_q32[sct_pkg::MB_W-1:0];
                mac_c = '0;
            end
            K_HORNER: begin
                mac_a = (r_k == K_LAST)
                      ? sct_pkg::coeff(sct_pkg::K_W'(MAX_TERM_INDEX), r_cos) : mac_q;
                mac_b = r_x2[sct_pkg::MB_W-1:0];
                mac_c = sct_pkg::coeff(sct_pkg::K_W'(r_k), r_cos);
            end
            K_FIN: begin
                mac_a = mac_q;
                mac_b = x_q32[sct_pkg::MB_W-1:0];
                mac_c = '0;
            end
            default: begin
                mac_a = '0;
                mac_b = '0;
                mac_c = '0;
            end
        endcase
    end

    assign mac_cmd.lo   = (r_state == ST_LO);
    assign mac_cmd.hi   = (r_state == ST_HI);
    assign mac_cmd.fold = (r_state == ST_FOLD);

    sct_mac u_mac (
        .i_clk (i_clk),
        .i_cmd (mac_cmd),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .i_c   (mac_c),
        .o_q   (mac_q)
    );

    // Floor to Q.16, then clamp to the Q4.16 range
    assign q_shift = mac_q[sct_pkg::ACC_W-1:16];
    always_comb begin
        if (sct_pkg::ACC_W'(q_shift) > SAT_MAX) begin
            q_sat = SAT_MAX[sct_pkg::VALUE_W-1:0];
        end else if (sct_pkg::ACC_W'(q_shift) < SAT_MIN) begin
            q_sat = SAT_MIN[sct_pkg::VALUE_W-1:0];
        end else begin
            q_sat = q_shift[sct_pkg::VALUE_W-1:0];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_k      = r_k;
        n_a      = r_a;
        n_cos    = r_cos;
        n_x2     = r_x2;
        n_odata  = r_odata;
        n_ovalid = r_ovalid && !m_tready;

        case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_a     = sct_pkg::RED_W'($signed(s_tdata[sct_pkg::ANGLE_W-1:0]));
                    n_cos   = (s_tuser == sct_pkg::FUNC_COSINE);
                    n_state = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                // subtract first, add only once the angle is no longer above 2*pi
                if (a_high) begin
                    n_a = a_dn;
                end else if (a_low) begin
                    n_a = a_up;
                end else begin
                    n_kind  = K_SQ;
                    n_state = ST_LO;
                end
            end
            ST_LO: begin
                n_state = ST_HI;
            end
            ST_HI: begin
                n_state = ST_FOLD;
            end
            ST_FOLD: begin
                case (r_kind)
                    K_SQ: begin
                        n_state = ST_X2;
                    end
                    K_HORNER: begin
                        if (r_k != '0) begin
                            n_k     = r_k - 1'b1;
                            n_state = ST_LO;
                        end else if (r_cos) begin
                            n_state = ST_DONE;
                        end else begin
                            n_kind  = K_FIN;
                            n_state = ST_LO;
                        end
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_X2: begin
                // hold x^2 and start the Horner loop at the top term
                n_x2    = mac_q;
                n_kind  = K_HORNER;
                n_k     = K_LAST;
                n_state = ST_LO;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_odata  = q_sat;
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_kind   <= K_SQ;
            r_k      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_kind   <= n_kind;
            r_k      <= n_k;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a     <= n_a;
        r_cos   <= n_cos;
        r_x2    <= n_x2;
        r_odata <= n_odata;
    end

    // An accepted request always starts with range reduction
    a_accept_reduce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> r_state == ST_REDUCE)
        else $error("accepted request did not enter reduction");

    // The series only ever sees an angle within [-2*pi, 2*pi]
    a_reduced_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LO && r_kind == K_SQ) |-> (r_a <= TWO_PI && r_a >= -TWO_PI))
        else $error("angle not reduced before squaring");

    // Term index stays inside the coefficient range during Horner steps
    a_term_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LO && r_kind == K_HORNER) |-> r_k <= K_LAST)
        else $error("term index out of range");

    // A new result appears only out of the final state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == ST_DONE)
        else $error("result raised outside the final state");

endmodule

// File: rtl/sct_mac.sv
module sct_mac (
    input  logic                                i_clk,
    input  sct_pkg::t_mac_cmd                   i_cmd,
    input  logic signed [sct_pkg::ACC_W-1:0]    i_a,
    input  logic signed [sct_pkg::MB_W-1:0]     i_b,
    input  logic signed [sct_pkg::ACC_W-1:0]    i_c,
    output logic signed [sct_pkg::ACC_W-1:0]    o_q
);

    logic signed [sct_pkg::MB_HALF:0]   b_digit;
    logic signed [sct_pkg::PP_W-1:0]    prod;
    logic signed [sct_pkg::PP_W-1:0]    r_pp;
    logic signed [sct_pkg::SUM_W-1:0]   r_sum;

    // Low digit is unsigned, high digit carries the sign of B
    assign b_digit = i_cmd.hi
        ? $signed({i_b[sct_pkg::MB_W-1], i_b[sct_pkg::MB_W-1:sct_pkg::MB_HALF]})
        : $signed({1'b0, i_b[sct_pkg::MB_HALF-1:0]});

    assign prod = i_a * b_digit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.lo || i_cmd.hi) begin
            r_pp <= prod;
        end
        if (i_cmd.hi) begin
            // seed with c at Q.32 so the floor of the sum already includes it
            r_sum <= (sct_pkg::SUM_W'(i_c) <<< sct_pkg::Q_FRAC) + sct_pkg::SUM_W'(r_pp);
        end else if (i_cmd.fold) begin
            r_sum <= r_sum + (sct_pkg::SUM_W'(r_pp) <<< sct_pkg::MB_HALF);
        end
    end

    // Arithmetic shift by 32 is the floor of the Q.32 product
    assign o_q = r_sum[sct_pkg::Q_FRAC +: sct_pkg::ACC_W];

endmodule
